### rtl/core/multichannel_delta_codec_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the delta codec RTL.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_DELTA_CODEC_UNIT_ASSERT_SVH
`define MULTICHANNEL_DELTA_CODEC_UNIT_ASSERT_SVH

// same-cycle implication
`define MDC_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("mdc assertion failed");

// next-cycle implication
`define MDC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("mdc assertion failed");

`endif

### rtl/core/mdc_pkg.sv
// ----------------------------------------------------------------------------
// mdc_pkg
// Types, widths and constants shared by the delta codec modules.
// ----------------------------------------------------------------------------
package mdc_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int MAX_WINDOW   = 256;
    localparam int WIN_LIMIT    = (MAX_WINDOW > 256) ? 256 : MAX_WINDOW;

    localparam int CH_W    = 3;
    localparam int TS_W    = 8;
    localparam int VAL_W   = 17;
    localparam int SMP_W   = 16;
    localparam int BYTES_W = 13;
    localparam int NCH_W   = 4;
    localparam int WIN_W   = 9;
    localparam int MODE_W  = 2;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 9;

    localparam int SMALL_LOW    = -127;
    localparam int SMALL_HIGH   = 127;
    localparam int HEADER_BYTES = 4;

    localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELTA = 2'd1;
    localparam logic              DIR_ENCODE = 1'b0;

    typedef enum logic [IDX_W-1:0] {
        REG_DIRECTION = 3'd0,
        REG_MODE      = 3'd1,
        REG_CHANNELS  = 3'd2,
        REG_WINDOW    = 3'd3
    } reg_idx_t;

    typedef struct packed {
        logic              direction;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [CH_W-1:0]         channel;
        logic [TS_W-1:0]         time_step;
        logic                    first;
        logic                    last;
    } item_t;

endpackage

### rtl/core/multichannel_delta_codec_unit.sv
// ----------------------------------------------------------------------------
// multichannel_delta_codec_unit: per-channel delta encode / decode of samples
// Throughput: one item per cycle, set by the single read and write port of the sample RAM,
// unless result_stall holds the output. Path: RAM read stage, then result register.
// Reset: config to defaults, counters, accumulator and valids clear; RAM is not cleared.
// ----------------------------------------------------------------------------
module multichannel_delta_codec_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mdc_pkg::IDX_W-1:0]          cfg_index,
    input  logic [mdc_pkg::DATA_W-1:0]         cfg_data,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  logic signed [mdc_pkg::VAL_W-1:0]   value_in,
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic signed [mdc_pkg::VAL_W-1:0]   value_out,
    output logic [mdc_pkg::CH_W-1:0]           channel,
    output logic [mdc_pkg::TS_W-1:0]           time_step,
    output logic                               chunk_last,
    output logic [mdc_pkg::BYTES_W-1:0]        chunk_bytes
);

    mdc_pkg::item_t               item;
    mdc_pkg::cfg_t                cfg;
    logic                         restart;
    logic                         busy;
    logic                         accept;
    logic [mdc_pkg::SMP_W-1:0]    rd_data;
    logic                         wr_en;
    logic [mdc_pkg::CH_W-1:0]     wr_addr;
    logic [mdc_pkg::SMP_W-1:0]    wr_data;

    assign accept = sample_valid && !sample_stall;

    mdc_sequencer u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .accept    (accept),
        .value_in  (value_in),
        .item      (item),
        .cfg       (cfg),
        .restart   (restart)
    );

    mdc_state_ram u_ram
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (item.channel),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    mdc_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .cfg         (cfg),
        .restart     (restart),
        .in_stall    (sample_stall),
        .busy        (busy),
        .rd_data     (rd_data),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .out_valid   (result_valid),
        .out_stall   (result_stall),
        .value_out   (value_out),
        .channel     (channel),
        .time_step   (time_step),
        .chunk_last  (chunk_last),
        .chunk_bytes (chunk_bytes)
    );

endmodule

### rtl/core/mdc_state_ram.sv
// ----------------------------------------------------------------------------
// mdc_state_ram
// Per-channel previous-sample store, one write and one registered read port.
// ----------------------------------------------------------------------------
module mdc_state_ram
(
    input  logic                           clk,
    input  logic                           rd_en,
    input  logic [mdc_pkg::CH_W-1:0]       rd_addr,
    output logic [mdc_pkg::SMP_W-1:0]      rd_data,
    input  logic                           wr_en,
    input  logic [mdc_pkg::CH_W-1:0]       wr_addr,
    input  logic [mdc_pkg::SMP_W-1:0]      wr_data
);

    logic [mdc_pkg::SMP_W-1:0] mem [mdc_pkg::MAX_CHANNELS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/mdc_sequencer.sv
// ----------------------------------------------------------------------------
// mdc_sequencer
// Configuration registers and channel / time-step counters of the chunk.
// ----------------------------------------------------------------------------
module mdc_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mdc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [mdc_pkg::DATA_W-1:0]        cfg_data,
    input  logic                              busy,
    input  logic                              accept,
    input  logic signed [mdc_pkg::VAL_W-1:0]  value_in,
    output mdc_pkg::item_t                    item,
    output mdc_pkg::cfg_t                     cfg,
    output logic                              restart
);

    logic                               direction_reg;
    logic [mdc_pkg::MODE_W-1:0]         mode_reg;
    logic [mdc_pkg::NCH_W-1:0]          channels_reg;
    logic [mdc_pkg::WIN_W-1:0]          window_reg;
    logic [mdc_pkg::CH_W-1:0]           ch_reg;
    logic [mdc_pkg::CH_W-1:0]           ch_next;
    logic [mdc_pkg::TS_W-1:0]           ts_reg;
    logic [mdc_pkg::TS_W-1:0]           ts_next;
    logic [mdc_pkg::NCH_W-1:0]          nch_eff;
    logic [mdc_pkg::WIN_W-1:0]          win_eff;
    logic                               ch_wrap;
    logic                               ts_wrap;
    logic                               last;
    logic                               cfg_wr;
    logic                               known_idx;

    assign cfg_ready = !busy && !accept;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_comb
    begin
        unique case (cfg_index)
            mdc_pkg::REG_DIRECTION,
            mdc_pkg::REG_MODE,
            mdc_pkg::REG_CHANNELS,
            mdc_pkg::REG_WINDOW: known_idx = 1'b1;
            default:             known_idx = 1'b0;
        endcase
    end

    assign restart = cfg_wr && known_idx;

    always_comb
    begin
        if (channels_reg == '0)
            nch_eff = mdc_pkg::NCH_W'(1);
        else if (channels_reg > mdc_pkg::NCH_W'(mdc_pkg::MAX_CHANNELS))
            nch_eff = mdc_pkg::NCH_W'(mdc_pkg::MAX_CHANNELS);
        else
            nch_eff = channels_reg;

        if (window_reg == '0)
            win_eff = mdc_pkg::WIN_W'(1);
        else if (window_reg > mdc_pkg::WIN_W'(mdc_pkg::WIN_LIMIT))
            win_eff = mdc_pkg::WIN_W'(mdc_pkg::WIN_LIMIT);
        else
            win_eff = window_reg;
    end

    assign ch_wrap = ({1'b0, ch_reg} + mdc_pkg::NCH_W'(1)) >= nch_eff;
    assign ts_wrap = ({1'b0, ts_reg} + mdc_pkg::WIN_W'(1)) >= win_eff;
    assign last    = ch_wrap && ts_wrap;

    always_comb
    begin
        ch_next = ch_reg;
        ts_next = ts_reg;
        if (restart)
        begin
            ch_next = '0;
            ts_next = '0;
        end
        else if (accept)
        begin
            if (last)
            begin
                ch_next = '0;
                ts_next = '0;
            end
            else if (ch_wrap)
            begin
                ch_next = '0;
                ts_next = ts_reg + mdc_pkg::TS_W'(1);
            end
            else
            begin
                ch_next = ch_reg + mdc_pkg::CH_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= mdc_pkg::DIR_ENCODE;
            mode_reg      <= mdc_pkg::MODE_DELTA;
            channels_reg  <= mdc_pkg::NCH_W'(8);
            window_reg    <= mdc_pkg::WIN_W'(256);
            ch_reg        <= '0;
            ts_reg        <= '0;
        end
        else
        begin
            ch_reg <= ch_next;
            ts_reg <= ts_next;
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    mdc_pkg::REG_DIRECTION: direction_reg <= cfg_data[0];
                    mdc_pkg::REG_MODE:      mode_reg      <= cfg_data[mdc_pkg::MODE_W-1:0];
                    mdc_pkg::REG_CHANNELS:  channels_reg  <= cfg_data[mdc_pkg::NCH_W-1:0];
                    mdc_pkg::REG_WINDOW:    window_reg    <= cfg_data[mdc_pkg::WIN_W-1:0];
                    default:                ;
                endcase
            end
        end
    end

    assign item.value     = value_in;
    assign item.channel   = ch_reg;
    assign item.time_step = ts_reg;
    assign item.first     = (ts_reg == '0);
    assign item.last      = last;

    assign cfg.direction  = direction_reg;
    assign cfg.mode       = mode_reg;

endmodule

### rtl/core/mdc_datapath.sv
// ----------------------------------------------------------------------------
// mdc_datapath
// Read-modify-write stage with forwarding, byte accumulator and result register.
// ----------------------------------------------------------------------------
`include "multichannel_delta_codec_unit_assert.svh"

module mdc_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  mdc_pkg::item_t                     item,
    input  mdc_pkg::cfg_t                      cfg,
    input  logic                               restart,
    output logic                               in_stall,
    output logic                               busy,
    input  logic [mdc_pkg::SMP_W-1:0]          rd_data,
    output logic                               wr_en,
    output logic [mdc_pkg::CH_W-1:0]           wr_addr,
    output logic [mdc_pkg::SMP_W-1:0]          wr_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [mdc_pkg::VAL_W-1:0]   value_out,
    output logic [mdc_pkg::CH_W-1:0]           channel,
    output logic [mdc_pkg::TS_W-1:0]           time_step,
    output logic                               chunk_last,
    output logic [mdc_pkg::BYTES_W-1:0]        chunk_bytes
);

    localparam logic signed [mdc_pkg::VAL_W-1:0] SmallLow  = mdc_pkg::VAL_W'(mdc_pkg::SMALL_LOW);
    localparam logic signed [mdc_pkg::VAL_W-1:0] SmallHigh = mdc_pkg::VAL_W'(mdc_pkg::SMALL_HIGH);

    logic                               s1_valid_reg;
    mdc_pkg::item_t                     s1_item_reg;
    logic                               fwd_hit_reg;
    logic [mdc_pkg::SMP_W-1:0]          fwd_data_reg;
    logic [mdc_pkg::BYTES_W-1:0]        acc_reg;
    logic [mdc_pkg::BYTES_W-1:0]        acc_next;

    logic                               out_valid_reg;
    logic signed [mdc_pkg::VAL_W-1:0]   value_reg;
    logic [mdc_pkg::CH_W-1:0]           channel_reg;
    logic [mdc_pkg::TS_W-1:0]           time_step_reg;
    logic                               chunk_last_reg;
    logic [mdc_pkg::BYTES_W-1:0]        chunk_bytes_reg;

    logic                               out_free;
    logic                               advance;
    logic [mdc_pkg::SMP_W-1:0]          prev;
    logic [mdc_pkg::SMP_W-1:0]          x16;
    logic [mdc_pkg::SMP_W-1:0]          dec16;
    logic signed [mdc_pkg::VAL_W-1:0]   result;
    logic [mdc_pkg::SMP_W-1:0]          sample16;
    logic                               raw_pass;
    logic                               pack;
    logic                               small_res;
    logic [1:0]                         cost;
    logic [mdc_pkg::BYTES_W-1:0]        sum;
    logic [mdc_pkg::BYTES_W-1:0]        bytes_last;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign busy     = s1_valid_reg || out_valid_reg;

    assign prev     = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign x16      = s1_item_reg.value[mdc_pkg::SMP_W-1:0];
    assign raw_pass = (cfg.mode == mdc_pkg::MODE_RAW) || s1_item_reg.first;
    assign pack     = cfg.mode[1] && (cfg.direction == mdc_pkg::DIR_ENCODE);

    always_comb
    begin
        if (cfg.direction == mdc_pkg::DIR_ENCODE)
        begin
            dec16    = '0;
            sample16 = x16;
            if (raw_pass)
                result = {x16[mdc_pkg::SMP_W-1], x16};
            else
                result = {x16[mdc_pkg::SMP_W-1], x16} - {prev[mdc_pkg::SMP_W-1], prev};
        end
        else
        begin
            dec16    = raw_pass ? x16 : prev + x16;
            sample16 = dec16;
            result   = {dec16[mdc_pkg::SMP_W-1], dec16};
        end
    end

    assign small_res  = (result >= SmallLow) && (result <= SmallHigh);
    assign cost       = (pack && small_res) ? 2'd1 : 2'd2;
    assign sum        = acc_reg + mdc_pkg::BYTES_W'(cost);
    assign bytes_last = sum + (pack ? mdc_pkg::BYTES_W'(mdc_pkg::HEADER_BYTES) : '0);

    assign wr_en   = advance;
    assign wr_addr = s1_item_reg.channel;
    assign wr_data = sample16;

    always_comb
    begin
        acc_next = acc_reg;
        if (restart)
            acc_next = '0;
        else if (advance)
            acc_next = s1_item_reg.last ? '0 : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg  <= item;
            fwd_hit_reg  <= wr_en && (wr_addr == item.channel);
            fwd_data_reg <= wr_data;
        end
        if (advance)
        begin
            value_reg       <= result;
            channel_reg     <= s1_item_reg.channel;
            time_step_reg   <= s1_item_reg.time_step;
            chunk_last_reg  <= s1_item_reg.last;
            chunk_bytes_reg <= s1_item_reg.last ? bytes_last : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_out   = value_reg;
    assign channel     = channel_reg;
    assign time_step   = time_step_reg;
    assign chunk_last  = chunk_last_reg;
    assign chunk_bytes = chunk_bytes_reg;

    `MDC_ASSERT_IMPL(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_reg)
    `MDC_ASSERT_NEXT(a_item_held, clk, rst_n, s1_valid_reg && !out_free, s1_valid_reg)
    `MDC_ASSERT_NEXT(a_forward_hit, clk, rst_n, accept && wr_en && (wr_addr == item.channel),
                     fwd_hit_reg)
    `MDC_ASSERT_IMPL(a_bytes_only_last, clk, rst_n, out_valid_reg && !chunk_last_reg,
                     chunk_bytes_reg == '0)

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: multichannel_delta_codec_unit
// Drives a directed table, then random phases, through the sample channel,
// rewriting the registers between phases while the block is idle. A local
// predictor supplies results the table omits; outputs are checked in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int ITEM_TARGET  = 650;
    localparam int SETTLE       = 4;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 200;

    localparam logic [mdc_pkg::MODE_W-1:0] MODE_PACK  = 2'd2;
    localparam logic [mdc_pkg::MODE_W-1:0] MODE_ALIAS = 2'd3;
    localparam logic                       DIR_DECODE = 1'b1;
    localparam logic [mdc_pkg::IDX_W-1:0]  REG_SPARE  = 3'd6;

    typedef struct packed {
        logic signed [mdc_pkg::VAL_W-1:0] value;
        logic [mdc_pkg::CH_W-1:0]         channel;
        logic [mdc_pkg::TS_W-1:0]         time_step;
        logic                             last;
        logic [mdc_pkg::BYTES_W-1:0]      bytes;
    } codec_result_t;

    typedef struct {
        bit                               is_write;
        logic [mdc_pkg::IDX_W-1:0]        index;
        logic [mdc_pkg::DATA_W-1:0]       data;
        logic signed [mdc_pkg::VAL_W-1:0] value;
        bit                               has_result;
        codec_result_t                    result;
    } plan_row_t;

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              cfg_valid    = 1'b0;
    logic [mdc_pkg::IDX_W-1:0]         cfg_index    = '0;
    logic [mdc_pkg::DATA_W-1:0]        cfg_data     = '0;
    logic                              sample_valid = 1'b0;
    logic signed [mdc_pkg::VAL_W-1:0]  value_in     = '0;
    logic                              result_stall = 1'b0;
    logic                              cfg_ready;
    logic                              sample_stall;
    logic                              result_valid;
    logic signed [mdc_pkg::VAL_W-1:0]  value_out;
    logic [mdc_pkg::CH_W-1:0]          channel;
    logic [mdc_pkg::TS_W-1:0]          time_step;
    logic                              chunk_last;
    logic [mdc_pkg::BYTES_W-1:0]       chunk_bytes;

    logic                              cfg_direction = mdc_pkg::DIR_ENCODE;
    logic [mdc_pkg::MODE_W-1:0]        cfg_mode      = mdc_pkg::MODE_DELTA;
    logic [mdc_pkg::NCH_W-1:0]         cfg_channels  = 4'd8;
    logic [mdc_pkg::WIN_W-1:0]         cfg_window    = 9'd256;
    logic signed [mdc_pkg::SMP_W-1:0]  last_sample [mdc_pkg::MAX_CHANNELS] = '{default: '0};
    logic [mdc_pkg::CH_W-1:0]          chan_count    = '0;
    logic [mdc_pkg::TS_W-1:0]          step_count    = '0;
    logic [mdc_pkg::BYTES_W-1:0]       bytes_so_far  = '0;
    logic [mdc_pkg::SMP_W-1:0]         walk [mdc_pkg::MAX_CHANNELS] = '{default: '0};

    codec_result_t            awaited_outputs [$];
    plan_row_t                plan [$];
    int                       errors       = 0;
    int                       samples_sent = 0;
    int                       results_seen = 0;
    int                       cycle_count  = 0;
    bit                       burst        = 1'b0;
    bit                       hold_active  = 1'b0;
    bit                       hold_done    = 1'b0;

    multichannel_delta_codec_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .value_in     (value_in),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .value_out    (value_out),
        .channel      (channel),
        .time_step    (time_step),
        .chunk_last   (chunk_last),
        .chunk_bytes  (chunk_bytes)
    );

    always #1 clk = ~clk;

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL multichannel_delta_codec_unit");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, results_seen, msg);
        errors++;
    endtask

    function automatic int eff_channels();
        int n;
        n = int'(cfg_channels);
        if (n < 1) n = 1;
        if (n > mdc_pkg::MAX_CHANNELS) n = mdc_pkg::MAX_CHANNELS;
        return n;
    endfunction

    function automatic int eff_window();
        int w;
        w = int'(cfg_window);
        if (w < 1) w = 1;
        if (w > mdc_pkg::WIN_LIMIT) w = mdc_pkg::WIN_LIMIT;
        return w;
    endfunction

    function automatic void clear_position();
        chan_count   = '0;
        step_count   = '0;
        bytes_so_far = '0;
    endfunction

    function automatic codec_result_t code_next_sample(
        input logic signed [mdc_pkg::VAL_W-1:0] v);
        codec_result_t r;
        int nch, win, ch, ts, prev, res, cost, total, sum;
        logic signed [mdc_pkg::SMP_W-1:0] s16;
        bit pack, first, last;
        nch   = eff_channels();
        win   = eff_window();
        ch    = int'(chan_count);
        ts    = int'(step_count);
        pack  = (cfg_mode >= MODE_PACK) && (cfg_direction == mdc_pkg::DIR_ENCODE);
        first = (ts == 0);
        prev  = int'(last_sample[ch]);
        cost  = 2;
        if (cfg_direction == mdc_pkg::DIR_ENCODE)
        begin
            s16 = v[mdc_pkg::SMP_W-1:0];
            res = (cfg_mode == mdc_pkg::MODE_RAW || first) ? int'(s16) : int'(s16) - prev;
            last_sample[ch] = s16;
            if (pack && res >= mdc_pkg::SMALL_LOW && res <= mdc_pkg::SMALL_HIGH)
                cost = 1;
        end
        else
        begin
            sum = (cfg_mode == mdc_pkg::MODE_RAW || first) ? int'(v) : prev + int'(v);
            s16 = sum[mdc_pkg::SMP_W-1:0];
            res = int'(s16);
            last_sample[ch] = s16;
        end
        last        = (ch + 1 >= nch) && (ts + 1 >= win);
        r.value     = res[mdc_pkg::VAL_W-1:0];
        r.channel   = ch[mdc_pkg::CH_W-1:0];
        r.time_step = ts[mdc_pkg::TS_W-1:0];
        r.last      = last;
        r.bytes     = '0;
        if (last)
        begin
            total   = int'(bytes_so_far) + cost + (pack ? mdc_pkg::HEADER_BYTES : 0);
            r.bytes = total[mdc_pkg::BYTES_W-1:0];
            clear_position();
        end
        else
        begin
            bytes_so_far = bytes_so_far + cost[mdc_pkg::BYTES_W-1:0];
            if (ch + 1 >= nch)
            begin
                chan_count = '0;
                step_count = step_count + 1'b1;
            end
            else
                chan_count = chan_count + 1'b1;
        end
        return r;
    endfunction

    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [mdc_pkg::VAL_W-1:0] make_value(input bit smooth);
        logic signed [mdc_pkg::VAL_W-1:0] v;
        int c;
        c = int'(chan_count);
        if (!smooth || $urandom_range(0, 19) == 0)
            v = mdc_pkg::VAL_W'($urandom_range(0, 131070) - 65535);
        else if (cfg_direction == mdc_pkg::DIR_ENCODE)
        begin
            walk[c] = walk[c] + mdc_pkg::SMP_W'($urandom_range(0, 300) - 150);
            v = {1'($urandom_range(0, 1)), walk[c]};
            if (v == 17'sh10000)
                v = '0;
        end
        else
            v = mdc_pkg::VAL_W'($urandom_range(0, 400) - 200);
        return v;
    endfunction

    task automatic write_reg(input logic [mdc_pkg::IDX_W-1:0] idx,
                             input logic [mdc_pkg::DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        case (idx)
            mdc_pkg::REG_DIRECTION: cfg_direction = data[0];
            mdc_pkg::REG_MODE:      cfg_mode      = data[mdc_pkg::MODE_W-1:0];
            mdc_pkg::REG_CHANNELS:  cfg_channels  = data[mdc_pkg::NCH_W-1:0];
            mdc_pkg::REG_WINDOW:    cfg_window    = data[mdc_pkg::WIN_W-1:0];
            default:                return;
        endcase
        clear_position();
    endtask

    task automatic send_sample(input logic signed [mdc_pkg::VAL_W-1:0] v, input bit typed,
                               input codec_result_t want);
        codec_result_t predicted;
        int gap;
        sample_valid <= 1'b1;
        value_in     <= v;
        do @(posedge clk); while (sample_stall !== 1'b0);
        predicted = code_next_sample(v);
        awaited_outputs.push_back(typed ? want : predicted);
        samples_sent++;
        gap = (burst || hold_active) ? 0 : idle_length();
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic quiesce();
        sample_valid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic random_phase(input int kind);
        logic [mdc_pkg::DATA_W-1:0] dir_w, mode_w, chan_w, win_w;
        int span, n_items, r;
        bit smooth;
        quiesce();
        dir_w  = mdc_pkg::DATA_W'($urandom);
        mode_w = mdc_pkg::DATA_W'($urandom);
        chan_w = mdc_pkg::DATA_W'($urandom);
        win_w  = mdc_pkg::DATA_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 5)
            chan_w[mdc_pkg::NCH_W-1:0] = '0;
        else if (r < 15)
            chan_w[mdc_pkg::NCH_W-1:0] =
                mdc_pkg::NCH_W'($urandom_range(mdc_pkg::MAX_CHANNELS + 1, 15));
        else
            chan_w[mdc_pkg::NCH_W-1:0] =
                mdc_pkg::NCH_W'($urandom_range(1, mdc_pkg::MAX_CHANNELS));
        r = $urandom_range(0, 99);
        if (r < 8)
            win_w = '0;
        else if (r < 16)
            win_w = mdc_pkg::DATA_W'($urandom_range(256, 511));
        else if (r < 30)
            win_w = mdc_pkg::DATA_W'($urandom_range(9, 40));
        else
            win_w = mdc_pkg::DATA_W'($urandom_range(1, 8));
        if (kind == 1)
        begin
            dir_w[0] = mdc_pkg::DIR_ENCODE;
            mode_w   = mdc_pkg::DATA_W'(MODE_PACK);
            chan_w   = 9'd1;
            win_w    = 9'h1FF;
        end
        else if (kind == 2)
        begin
            dir_w[0] = DIR_DECODE;
            mode_w   = mdc_pkg::DATA_W'(mdc_pkg::MODE_DELTA);
            chan_w   = 9'd8;
            win_w    = 9'd256;
        end
        if (kind != 0 || $urandom_range(0, 9) < 6) write_reg(mdc_pkg::REG_DIRECTION, dir_w);
        if (kind != 0 || $urandom_range(0, 9) < 6) write_reg(mdc_pkg::REG_MODE, mode_w);
        if (kind != 0 || $urandom_range(0, 9) < 6) write_reg(mdc_pkg::REG_CHANNELS, chan_w);
        if (kind != 0 || $urandom_range(0, 9) < 6) write_reg(mdc_pkg::REG_WINDOW, win_w);
        if ($urandom_range(0, 9) == 0)
            write_reg(mdc_pkg::IDX_W'($urandom_range(mdc_pkg::REG_WINDOW + 1, 7)),
                      mdc_pkg::DATA_W'($urandom));
        cfg_valid <= 1'b0;
        span = eff_channels() * eff_window();
        if (kind == 1)
            n_items = 256;
        else if (kind == 2)
            n_items = 60;
        else if (span <= 48)
            n_items = span * $urandom_range(1, 3)
                      + (($urandom_range(0, 3) == 0) ? $urandom_range(0, span - 1) : 0);
        else
            n_items = $urandom_range(16, 64);
        smooth = (kind == 1) || ($urandom_range(0, 3) != 0);
        burst  = (kind == 0) && ($urandom_range(0, 4) == 0);
        repeat (n_items) send_sample(make_value(smooth), 1'b0, '0);
        burst = 1'b0;
    endtask

    function automatic plan_row_t write_row(input logic [mdc_pkg::IDX_W-1:0] idx,
                                            input logic [mdc_pkg::DATA_W-1:0] data);
        plan_row_t row;
        row          = '{default: '0};
        row.is_write = 1'b1;
        row.index    = idx;
        row.data     = data;
        return row;
    endfunction

    function automatic plan_row_t sample_row(input logic signed [mdc_pkg::VAL_W-1:0] v);
        plan_row_t row;
        row       = '{default: '0};
        row.value = v;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input logic signed [mdc_pkg::VAL_W-1:0] v,
                                            input int val, input int ch, input int ts,
                                            input bit last, input int bytes);
        plan_row_t row;
        row                  = sample_row(v);
        row.has_result       = 1'b1;
        row.result.value     = val[mdc_pkg::VAL_W-1:0];
        row.result.channel   = ch[mdc_pkg::CH_W-1:0];
        row.result.time_step = ts[mdc_pkg::TS_W-1:0];
        row.result.last      = last;
        row.result.bytes     = bytes[mdc_pkg::BYTES_W-1:0];
        return row;
    endfunction

    initial
    begin : result_side
        int n;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!hold_done && samples_sent >= HOLD_AT)
            begin
                hold_active = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
                hold_done   = 1'b1;
            end
            result_stall <= 1'b0;
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 6) : $urandom_range(20, 120);
            repeat (n) @(posedge clk);
            n = idle_length();
            if (n > 0)
            begin
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        codec_result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (awaited_outputs.size() == 0)
                report_mismatch("result transfer with nothing awaited");
            else
            begin
                want = awaited_outputs.pop_front();
                if (value_out !== want.value)
                    report_mismatch($sformatf("value_out %0d, want %0d", value_out, want.value));
                if (channel !== want.channel)
                    report_mismatch($sformatf("channel %0d, want %0d", channel, want.channel));
                if (time_step !== want.time_step)
                    report_mismatch($sformatf("time_step %0d, want %0d", time_step,
                                              want.time_step));
                if (chunk_last !== want.last)
                    report_mismatch($sformatf("chunk_last %0b, want %0b", chunk_last, want.last));
                if (chunk_bytes !== want.bytes)
                    report_mismatch($sformatf("chunk_bytes %0d, want %0d", chunk_bytes,
                                              want.bytes));
                results_seen++;
            end
        end
    end

    initial
    begin : stimulus
        plan_row_t row;
        bit writing;
        wait (rst_n === 1'b1);
        @(posedge clk);

        plan.push_back(typed_row(17'sd32767, 32767, 0, 0, 0, 0));
        plan.push_back(sample_row(-17'sd1));
        plan.push_back(write_row(mdc_pkg::REG_WINDOW, 9'd1));
        plan.push_back(write_row(mdc_pkg::REG_CHANNELS, 9'd1));
        plan.push_back(typed_row(-17'sd65535, 1, 0, 0, 1, 2));
        plan.push_back(typed_row(17'sd65535, -1, 0, 0, 1, 2));
        plan.push_back(typed_row(17'sd32768, -32768, 0, 0, 1, 2));
        plan.push_back(write_row(mdc_pkg::REG_MODE, mdc_pkg::DATA_W'(MODE_PACK)));
        plan.push_back(typed_row(17'sd127, 127, 0, 0, 1, 5));
        plan.push_back(typed_row(-17'sd128, -128, 0, 0, 1, 6));
        plan.push_back(write_row(mdc_pkg::REG_MODE, mdc_pkg::DATA_W'(MODE_ALIAS)));
        plan.push_back(typed_row(-17'sd127, -127, 0, 0, 1, 5));
        plan.push_back(write_row(mdc_pkg::REG_WINDOW, 9'd0));
        plan.push_back(typed_row(17'sd128, 128, 0, 0, 1, 6));
        plan.push_back(write_row(mdc_pkg::REG_WINDOW, 9'd2));
        plan.push_back(typed_row(17'sd32767, 32767, 0, 0, 0, 0));
        plan.push_back(typed_row(-17'sd32768, -65535, 0, 1, 1, 8));
        plan.push_back(typed_row(-17'sd32768, -32768, 0, 0, 0, 0));
        plan.push_back(typed_row(17'sd32767, 65535, 0, 1, 1, 8));
        plan.push_back(write_row(mdc_pkg::REG_DIRECTION, mdc_pkg::DATA_W'(DIR_DECODE)));
        plan.push_back(typed_row(-17'sd65535, 1, 0, 0, 0, 0));
        plan.push_back(typed_row(17'sd65535, 0, 0, 1, 1, 4));
        plan.push_back(write_row(mdc_pkg::REG_MODE, mdc_pkg::DATA_W'(mdc_pkg::MODE_RAW)));
        plan.push_back(write_row(mdc_pkg::REG_CHANNELS, 9'd0));
        plan.push_back(sample_row(17'sh0ABCD));
        plan.push_back(sample_row(17'sh1F00F));
        plan.push_back(write_row(mdc_pkg::REG_CHANNELS, 9'd15));
        plan.push_back(write_row(mdc_pkg::REG_MODE, mdc_pkg::DATA_W'(mdc_pkg::MODE_DELTA)));
        plan.push_back(write_row(mdc_pkg::REG_DIRECTION,
                                 mdc_pkg::DATA_W'(mdc_pkg::DIR_ENCODE)));
        plan.push_back(write_row(mdc_pkg::REG_WINDOW, 9'h1FF));
        plan.push_back(sample_row(17'sh00100));
        plan.push_back(sample_row(-17'sd300));
        plan.push_back(sample_row(17'sh17FFF));
        plan.push_back(sample_row(17'sh08000));
        plan.push_back(write_row(REG_SPARE, 9'h1FF));
        plan.push_back(sample_row(17'sh0FF80));
        plan.push_back(sample_row(17'sd5));

        writing = 1'b0;
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.is_write)
            begin
                if (!writing)
                    quiesce();
                write_reg(row.index, row.data);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    cfg_valid <= 1'b0;
                writing = 1'b0;
                send_sample(row.value, row.has_result, row.result);
            end
        end

        random_phase(1);
        random_phase(2);
        while (samples_sent < ITEM_TARGET)
            random_phase(0);

        quiesce();
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("PASS multichannel_delta_codec_unit");
        else
            $display("FAIL multichannel_delta_codec_unit");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/mdc_pkg.sv
rtl/core/mdc_state_ram.sv
rtl/core/mdc_sequencer.sv
rtl/core/mdc_datapath.sv
rtl/core/multichannel_delta_codec_unit.sv
sim/testbench.sv
